/* src/assert_macros.svh */
// Assertion macros shared by the lexer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define STL_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("lexer assertion failed");
`define STL_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("lexer assertion failed");
`define STL_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("lexer assertion failed");
`else
`define STL_ASSERT(lbl, clk, rst_n, prop)
`define STL_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`define STL_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

/* src/stl_pkg.sv */
// Types, token codes and character classes of the source text lexer.
package stl_pkg;
	localparam int unsigned FIELD_W = 16;
	localparam int unsigned KIND_W = 4;

	localparam logic [KIND_W-1:0] KIND_IDENT = 4'd0;
	localparam logic [KIND_W-1:0] KIND_EXIT = 4'd1;
	localparam logic [KIND_W-1:0] KIND_NUM = 4'd2;
	localparam logic [KIND_W-1:0] KIND_PLUS = 4'd3;
	localparam logic [KIND_W-1:0] KIND_MINUS = 4'd4;
	localparam logic [KIND_W-1:0] KIND_STAR = 4'd5;
	localparam logic [KIND_W-1:0] KIND_SLASH = 4'd6;
	localparam logic [KIND_W-1:0] KIND_ASSIGN = 4'd7;
	localparam logic [KIND_W-1:0] KIND_LPAREN = 4'd8;
	localparam logic [KIND_W-1:0] KIND_RPAREN = 4'd9;
	localparam logic [KIND_W-1:0] KIND_LCURLY = 4'd10;
	localparam logic [KIND_W-1:0] KIND_RCURLY = 4'd11;
	localparam logic [KIND_W-1:0] KIND_COLON = 4'd12;
	localparam logic [KIND_W-1:0] KIND_SEMI = 4'd13;
	localparam logic [KIND_W-1:0] KIND_NEWLINE = 4'd14;
	// Not a token: the byte is skipped.
	localparam logic [KIND_W-1:0] KIND_NONE = 4'd15;

	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_IDENT = 2'd1;
	localparam logic [1:0] MODE_NUM = 2'd2;

	localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
	localparam logic [7:0] CHAR_E = 8'h65;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [FIELD_W-1:0] line;
		logic [FIELD_W-1:0] column;
		logic [FIELD_W-1:0] offset;
		logic [FIELD_W-1:0] length;
		logic last;
	} token_t;

	// Tokens produced by one byte, handed to the output queue.
	typedef struct packed {
		logic [1:0] count;
		token_t tok0;
		token_t tok1;
	} push_t;

	function automatic logic is_letter(logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic [7:0] kw_exit_char(logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0: c = 8'h65;
			2'd1: c = 8'h78;
			2'd2: c = 8'h69;
			default: c = 8'h74;
		endcase
		return c;
	endfunction

	function automatic logic [KIND_W-1:0] single_kind(logic [7:0] b);
		logic [KIND_W-1:0] k;
		case (b)
			8'h2b: k = KIND_PLUS;
			8'h2d: k = KIND_MINUS;
			8'h2a: k = KIND_STAR;
			8'h2f: k = KIND_SLASH;
			8'h3d: k = KIND_ASSIGN;
			8'h28: k = KIND_LPAREN;
			8'h29: k = KIND_RPAREN;
			8'h7b: k = KIND_LCURLY;
			8'h7d: k = KIND_RCURLY;
			8'h3a: k = KIND_COLON;
			8'h3b: k = KIND_SEMI;
			CHAR_NEWLINE: k = KIND_NEWLINE;
			default: k = KIND_NONE;
		endcase
		return k;
	endfunction
endpackage

/* src/source_text_lexer.sv */
// Top level of the source text lexer: input stage, token forming and result queue.
//
//  channel   handshake            payload
//  input     in_valid/in_ready    text_byte, end_of_text
//  output    out_valid/out_ready  token_kind, token_line, token_column,
//                                 value_offset, value_length, last_for_input
//
// One byte per cycle enters while the queue has room; its tokens are formed from the
// input register and written to the result queue. A byte that closes a run and gives
// a second token pushes two tokens, which leave through the single output port in turn.
// The input stage waits while the queue has fewer than two free entries.
// Reset puts the position at line 1, column 1, offset 0 with no run open.
module source_text_lexer #(
	parameter int unsigned POSITION_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] text_byte,
	input logic end_of_text,
	output logic out_valid,
	input logic out_ready,
	output logic [3:0] token_kind,
	output logic [15:0] token_line,
	output logic [15:0] token_column,
	output logic [15:0] value_offset,
	output logic [15:0] value_length,
	output logic last_for_input
);
	import stl_pkg::*;

	push_t push;
	logic room;
	token_t head;

	stl_core #(
		.POSITION_BITS(POSITION_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.text_byte(text_byte),
		.end_of_text(end_of_text),
		.room(room),
		.push(push)
	);

	stl_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head(head)
	);

	assign token_kind = head.kind;
	assign token_line = head.line;
	assign token_column = head.column;
	assign value_offset = head.offset;
	assign value_length = head.length;
	assign last_for_input = head.last;
endmodule

/* src/stl_core.sv */
// Input register, run and position state, and token forming for one byte.
`include "assert_macros.svh"
module stl_core #(
	parameter int unsigned POSITION_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] text_byte,
	input logic end_of_text,
	input logic room,
	output stl_pkg::push_t push
);
	import stl_pkg::*;

	localparam int unsigned P = POSITION_BITS;

	logic valid_s1;
	logic [7:0] byte_s1;
	logic eot_s1;

	logic [1:0] mode_q;
	logic [P-1:0] start_line_q, start_col_q, start_off_q, run_len_q;
	logic kw_q;
	logic [P-1:0] line_q, col_q, off_q;

	logic advance;
	logic letter, digit, cont, flush_first;
	logic [KIND_W-1:0] skind;
	logic [1:0] n_mode;
	logic [P-1:0] n_line, n_col, n_off, n_len;
	logic n_kw;
	token_t tok_flush, tok_eot, tok_single, tok_second;
	logic second_valid;

	function automatic logic [P-1:0] sat_inc(logic [P-1:0] v);
		return (v == {P{1'b1}}) ? v : v + P'(1);
	endfunction

	function automatic token_t run_token(logic [1:0] mode, logic [P-1:0] line,
			logic [P-1:0] col, logic [P-1:0] off, logic [P-1:0] len, logic kw);
		token_t t;
		t.line = FIELD_W'(line);
		t.column = FIELD_W'(col);
		t.offset = FIELD_W'(off);
		t.length = FIELD_W'(len);
		t.last = 1'b0;
		if (mode == MODE_NUM) begin
			t.kind = KIND_NUM;
		end else if (kw && len == P'(4)) begin
			t.kind = KIND_EXIT;
			t.offset = '0;
			t.length = '0;
		end else begin
			t.kind = KIND_IDENT;
		end
		return t;
	endfunction

	assign advance = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			byte_s1 <= text_byte;
			eot_s1 <= end_of_text;
		end
	end

	always_comb begin
		letter = is_letter(byte_s1);
		digit = is_digit(byte_s1);
		skind = single_kind(byte_s1);
		cont = (mode_q == MODE_IDENT && (letter || digit)) || (mode_q == MODE_NUM && digit);
		flush_first = !cont && mode_q != MODE_NONE;
		tok_flush = run_token(mode_q, start_line_q, start_col_q, start_off_q, run_len_q, kw_q);

		n_mode = mode_q;
		n_line = start_line_q;
		n_col = start_col_q;
		n_off = start_off_q;
		n_len = run_len_q;
		n_kw = kw_q;
		if (cont) begin
			if (kw_q && !(run_len_q < P'(4) && byte_s1 == kw_exit_char(run_len_q[1:0]))) begin
				n_kw = 1'b0;
			end
			n_len = sat_inc(run_len_q);
		end else if (letter || digit) begin
			n_mode = letter ? MODE_IDENT : MODE_NUM;
			n_line = line_q;
			n_col = col_q;
			n_off = off_q;
			n_len = P'(1);
			n_kw = byte_s1 == CHAR_E;
		end else begin
			n_mode = MODE_NONE;
			n_len = '0;
			n_kw = 1'b0;
		end

		tok_eot = run_token(n_mode, n_line, n_col, n_off, n_len, n_kw);
		tok_single.kind = skind;
		tok_single.line = FIELD_W'(line_q);
		tok_single.column = FIELD_W'(col_q);
		tok_single.offset = '0;
		tok_single.length = '0;
		tok_single.last = 1'b0;

		// A symbol only appears when no run is left open, so at most one of
		// the symbol token and the end-of-text flush exists.
		second_valid = (!cont && skind != KIND_NONE) || (eot_s1 && n_mode != MODE_NONE);
		tok_second = (!cont && skind != KIND_NONE) ? tok_single : tok_eot;
		tok_second.last = 1'b1;

		push.tok0 = flush_first ? tok_flush : tok_second;
		push.tok0.last = !(flush_first && second_valid);
		push.tok1 = tok_second;
		push.count = advance ? 2'(flush_first) + 2'(second_valid) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NONE;
			start_line_q <= P'(1);
			start_col_q <= P'(1);
			start_off_q <= '0;
			run_len_q <= '0;
			kw_q <= 1'b0;
			line_q <= P'(1);
			col_q <= P'(1);
			off_q <= '0;
		end else if (advance) begin
			mode_q <= eot_s1 ? MODE_NONE : n_mode;
			start_line_q <= n_line;
			start_col_q <= n_col;
			start_off_q <= n_off;
			run_len_q <= eot_s1 ? '0 : n_len;
			kw_q <= eot_s1 ? 1'b0 : n_kw;
			off_q <= sat_inc(off_q);
			if (byte_s1 == CHAR_NEWLINE) begin
				line_q <= sat_inc(line_q);
				col_q <= P'(1);
			end else begin
				col_q <= sat_inc(col_q);
			end
		end
	end

	`STL_ASSERT_NEXT(a_eot_closes_run, clk, arst_n, advance && eot_s1, mode_q == MODE_NONE)
	`STL_ASSERT(a_line_nonzero, clk, arst_n, line_q != '0 && col_q != '0)
	`STL_ASSERT_IMPL(a_open_run_has_length, clk, arst_n, mode_q != MODE_NONE, run_len_q != '0)
endmodule

/* src/stl_queue.sv */
// Three-entry result queue that takes up to two tokens per cycle.
`include "assert_macros.svh"
module stl_queue (
	input logic clk,
	input logic arst_n,
	input stl_pkg::push_t push,
	output logic room,
	output logic out_valid,
	input logic out_ready,
	output stl_pkg::token_t head
);
	import stl_pkg::*;

	localparam logic [1:0] DEPTH = 2'd3;

	token_t entries [3];
	logic [1:0] wr_q, rd_q, count_q;
	logic pop;
	logic [2:0] count_next;

	function automatic logic [1:0] inc3(logic [1:0] p);
		return (p == DEPTH - 2'd1) ? 2'd0 : p + 2'd1;
	endfunction

	assign pop = out_valid && out_ready;
	assign out_valid = count_q != 2'd0;
	assign head = entries[rd_q];
	// Room means two free entries once this cycle's request leaves.
	assign room = count_q <= 2'd1 || (count_q == 2'd2 && pop);
	assign count_next = 3'(count_q) + 3'(push.count) - 3'(pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 2'd0;
			rd_q <= 2'd0;
			count_q <= 2'd0;
		end else begin
			count_q <= count_next[1:0];
			if (pop) begin
				rd_q <= inc3(rd_q);
			end
			if (push.count == 2'd1) begin
				wr_q <= inc3(wr_q);
			end else if (push.count == 2'd2) begin
				wr_q <= inc3(inc3(wr_q));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entries[wr_q] <= push.tok0;
		end
		if (push.count == 2'd2) begin
			entries[inc3(wr_q)] <= push.tok1;
		end
	end

	`STL_ASSERT(a_no_overflow, clk, arst_n, count_next <= 3'(DEPTH))
	`STL_ASSERT(a_ptr_range, clk, arst_n, wr_q != 2'd3 && rd_q != 2'd3)
	`STL_ASSERT_NEXT(a_drain_empty, clk, arst_n,
		count_q == 2'd1 && pop && push.count == 2'd0, !out_valid)
endmodule
